>>> hdl/tcfb_pkg.sv
// shared types, constants and crc function for the tc transfer frame builder
`timescale 1ns / 1ps
package tcfb_pkg;

  localparam int MaxFrameBytesDef = 1024;
  localparam int QueueDepth = 4;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 10;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [9:0] TrailerPlusHdrM1 = 10'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [9:0] payload_length;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       status_code;
  } out_word_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VERSION = 3'd0,
    CFG_BYPASS  = 3'd1,
    CFG_CTRL    = 3'd2,
    CFG_SC_ID   = 3'd3,
    CFG_VC_ID   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_kind_e;

  typedef enum logic [2:0] {
    PH_W0_HI  = 3'd0,
    PH_W0_LO  = 3'd1,
    PH_W1_HI  = 3'd2,
    PH_W1_LO  = 3'd3,
    PH_SEQ    = 3'd4,
    PH_DATA   = 3'd5,
    PH_CRC_HI = 3'd6,
    PH_CRC_LO = 3'd7
  } phase_e;

  typedef struct packed {
    logic [15:0] w0;
    logic [15:0] w1;
    logic [7:0]  seq;
  } hdr_t;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       last;
    hdr_t       hdr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/tcfb_cmd_queue.sv
// short command queue between the classifier and the byte emitter
`timescale 1ns / 1ps
module tcfb_cmd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tcfb_pkg::cmd_t   push_cmd_i,
  input  logic             pop_i,
  output tcfb_pkg::cmd_t   head_cmd_o,
  output tcfb_pkg::q_stat_t stat_o
);
  import tcfb_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign head_cmd_o = mem_q[rd_ptr_q];
  assign stat_o     = '{full: (cnt_q == (QPtrW+1)'(QueueDepth)), empty: (cnt_q == '0)};

endmodule

>>> hdl/tcfb_front.sv
// front end: config registers, frame tracking and word classification
`timescale 1ns / 1ps
module tcfb_front #(
  parameter int MaxFrameBytes = tcfb_pkg::MaxFrameBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcfb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcfb_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tcfb_pkg::in_word_t            in_word_i,
  input  tcfb_pkg::q_stat_t             q_stat_i,
  output logic                          push_o,
  output tcfb_pkg::cmd_t                push_cmd_o
);
  import tcfb_pkg::*;

  localparam logic [9:0] LenLimit = 10'(MaxFrameBytes - 8);

  logic [1:0] version_q;
  logic       bypass_q;
  logic       ctrl_q;
  logic [9:0] sc_id_q;
  logic [5:0] vc_id_q;

  logic [9:0] rem_q, rem_d;
  logic       discard_q, discard_d;
  logic [7:0] seq_q, seq_d;

  logic       accept;
  logic [9:0] len_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= '0;
      bypass_q  <= 1'b1;
      ctrl_q    <= 1'b1;
      sc_id_q   <= '0;
      vc_id_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VERSION: version_q <= cfg_wdata_i[1:0];
        CFG_BYPASS:  bypass_q  <= cfg_wdata_i[0];
        CFG_CTRL:    ctrl_q    <= cfg_wdata_i[0];
        CFG_SC_ID:   sc_id_q   <= cfg_wdata_i[9:0];
        CFG_VC_ID:   vc_id_q   <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    len_sat = in_word_i.payload_length;
    if (len_sat == '0) begin
      len_sat = 10'd1;
    end
    if (len_sat > LenLimit) begin
      len_sat = LenLimit;
    end
  end

  always_comb begin
    rem_d      = rem_q;
    discard_d  = discard_q;
    seq_d      = seq_q;
    push_o     = 1'b0;
    push_cmd_o.kind     = CMD_DATA;
    push_cmd_o.data     = in_word_i.data_byte;
    push_cmd_o.last     = 1'b0;
    push_cmd_o.hdr.w0   = {version_q, bypass_q, ctrl_q, 2'b00, sc_id_q};
    push_cmd_o.hdr.w1   = {vc_id_q, len_sat + TrailerPlusHdrM1};
    push_cmd_o.hdr.seq  = seq_q;
    if (accept) begin
      if (rem_q != '0) begin
        rem_d = rem_q - 1'b1;
        if (discard_q) begin
          // rest of a rejected frame is swallowed
          if (rem_q == 10'd1) begin
            discard_d = 1'b0;
          end
        end else begin
          push_o          = 1'b1;
          push_cmd_o.last = (rem_q == 10'd1);
          if (rem_q == 10'd1) begin
            seq_d = seq_q + 1'b1;
          end
        end
      end else begin
        rem_d  = len_sat - 1'b1;
        push_o = 1'b1;
        if (!(bypass_q && ctrl_q)) begin
          push_cmd_o.kind = CMD_ERROR;
          discard_d       = (len_sat != 10'd1);
        end else begin
          push_cmd_o.kind = CMD_START;
          push_cmd_o.last = (len_sat == 10'd1);
          discard_d       = 1'b0;
          if (len_sat == 10'd1) begin
            seq_d = seq_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      discard_q <= 1'b0;
      seq_q     <= '0;
    end else begin
      rem_q     <= rem_d;
      discard_q <= discard_d;
      seq_q     <= seq_d;
    end
  end

endmodule

>>> hdl/tcfb_back.sv
// back end: walks each command out as bytes, runs the crc, output register
`timescale 1ns / 1ps
module tcfb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcfb_pkg::cmd_t      head_cmd_i,
  input  tcfb_pkg::q_stat_t   q_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcfb_pkg::out_word_t out_word_o
);
  import tcfb_pkg::*;

  logic [2:0]  step_q, step_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_word_q, out_word_d;

  logic        fire;
  logic        done;
  phase_e      phase;
  logic [7:0]  cur_byte;

  assign fire = !q_stat_i.empty && (!out_valid_q || !out_stall_i);

  // data commands skip the header phases
  assign phase = phase_e'((head_cmd_i.kind == CMD_DATA) ? step_q + 3'd5 : step_q);

  always_comb begin
    case (phase)
      PH_W0_HI:  cur_byte = head_cmd_i.hdr.w0[15:8];
      PH_W0_LO:  cur_byte = head_cmd_i.hdr.w0[7:0];
      PH_W1_HI:  cur_byte = head_cmd_i.hdr.w1[15:8];
      PH_W1_LO:  cur_byte = head_cmd_i.hdr.w1[7:0];
      PH_SEQ:    cur_byte = head_cmd_i.hdr.seq;
      PH_DATA:   cur_byte = head_cmd_i.data;
      PH_CRC_HI: cur_byte = crc_q[15:8];
      PH_CRC_LO: cur_byte = crc_q[7:0];
      default:   cur_byte = head_cmd_i.data;
    endcase
  end

  always_comb begin
    step_d      = step_q;
    crc_d       = crc_q;
    done        = 1'b0;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      out_valid_d = 1'b1;
      if (head_cmd_i.kind == CMD_ERROR) begin
        out_word_d = '{out_byte: 8'h00, frame_end: 1'b1, status_code: 1'b1};
        done       = 1'b1;
      end else begin
        out_word_d = '{out_byte: cur_byte, frame_end: (phase == PH_CRC_LO),
                       status_code: 1'b0};
        if (phase == PH_CRC_LO) begin
          crc_d = CrcInit;
          done  = 1'b1;
        end else if (phase != PH_CRC_HI) begin
          crc_d = crc16_byte(crc_q, cur_byte);
          done  = (phase == PH_DATA) && !head_cmd_i.last;
        end
      end
      step_d = done ? 3'd0 : step_q + 3'd1;
    end
  end

  assign pop_o = fire && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> hdl/tc_transfer_frame_builder.sv
// first result word is registered after the input word passes the command queue
// emitter sends one word per cycle unless stalled: a frame-opening input gives six
// words (eight if last, one if rejected), other payload words one (three if last)
// input is taken every cycle while the four-entry command queue has room
// reset clears frame state and sequence count, crc to all ones, config to defaults
`timescale 1ns / 1ps
module tc_transfer_frame_builder #(
  parameter int MaxFrameBytes = tcfb_pkg::MaxFrameBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcfb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcfb_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tcfb_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tcfb_pkg::out_word_t           out_word_o
);
  import tcfb_pkg::*;

  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head_cmd;
  q_stat_t q_stat;

  tcfb_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  tcfb_cmd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_cmd_o(head_cmd),
    .stat_o    (q_stat)
  );

  tcfb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_cmd_i (head_cmd),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule
